/* hw/rtl/usb_fifo_slot_allocator_core_macros.svh */
// Assertion helpers for the slot allocator. Each macro expands to one labeled
// concurrent assertion clocked on clk and disabled while rst_n is low.
`ifndef USB_FIFO_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define USB_FIFO_SLOT_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USBFSA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define USBFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`endif

/* hw/rtl/usbfsa_pkg.sv */
package usbfsa_pkg;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // RAM layout in 8-byte units.
    localparam int unsigned EP0_UNITS   = 16;
    localparam int unsigned SMALL_UNITS = 8;
    localparam int unsigned LARGE_UNITS = 32;

    // Slot sizes in bytes, used to classify allocate requests.
    localparam logic [10:0] SMALL_MAX_BYTES = 11'd64;
    localparam logic [10:0] LARGE_MAX_BYTES = 11'd256;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [10:0] packet_size;
        logic [11:0] fifo_address;
    } req_t;

    typedef struct packed {
        logic [11:0] slot_address;
        status_t     status;
    } rsp_t;

endpackage

/* hw/rtl/usbfsa_stream_if.sv */
interface usbfsa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/usbfsa_lowest_free.sv */
module usbfsa_lowest_free #(
    parameter int unsigned N = 2
) (
    input  logic [N-1:0]                      busy,
    output logic                              found,
    output logic [(N > 1 ? $clog2(N) : 1)-1:0] idx
);

    localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] grant;

    // Lowest clear bit: the carry of busy + 1 stops at the first zero.
    assign grant = ~busy & (busy + N'(1));
    assign found = |grant;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (grant[i])
            begin
                idx = idx | IW'(i);
            end
        end
    end

endmodule

/* hw/rtl/usb_fifo_slot_allocator_core.sv */
// Endpoint FIFO slot allocator for USB controller buffer RAM.
// The RAM holds a 128-byte endpoint-0 area, then SMALL_SLOTS 64-byte slots,
// then LARGE_SLOTS 256-byte slots; all addresses are in 8-byte units.
// Requests arrive on the req channel (mode, packet_size, fifo_address) and
// each one produces exactly one item on the rsp channel (slot_address,
// status). An allocate takes the lowest free small slot for sizes up to 64,
// falling back to the large pool, or the lowest free large slot for sizes up
// to 256. A free clears the busy bit of the slot containing the address.
// An accepted item is captured in the input register and moves on to the
// result register, which drives rsp, once that register is empty or drained.
// Throughput is one item per cycle while the receiver does not stall, set by
// the busy bitmap update, which is combinational and registered with each
// result so each request sees the masks left by the one before it.
// When the receiver stalls, the result register holds and the input register
// fills; req.ready drops only when both are occupied, so no item is lost.
// Reset marks every slot free and empties both registers; no clearing pass
// is needed.
`include "usb_fifo_slot_allocator_core_macros.svh"

module usb_fifo_slot_allocator_core #(
    parameter int unsigned SMALL_SLOTS = 2,
    parameter int unsigned LARGE_SLOTS = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    usbfsa_stream_if.sink   req,
    usbfsa_stream_if.source rsp
);

    localparam int unsigned SIDX_W = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
    localparam int unsigned LIDX_W = (LARGE_SLOTS > 1) ? $clog2(LARGE_SLOTS) : 1;

    // First unit past the small pool, which is also the large pool base.
    localparam int unsigned LARGE_BASE = usbfsa_pkg::EP0_UNITS
                                         + usbfsa_pkg::SMALL_UNITS * SMALL_SLOTS;
    localparam int unsigned LARGE_SPAN = usbfsa_pkg::LARGE_UNITS * LARGE_SLOTS;

    // Pipeline registers.
    logic               in_valid_reg;
    usbfsa_pkg::req_t   in_data_reg;
    logic               out_valid_reg;
    usbfsa_pkg::rsp_t   out_data_reg;

    // Busy bitmaps.
    logic [SMALL_SLOTS-1:0] small_busy_reg;
    logic [SMALL_SLOTS-1:0] small_busy_next;
    logic [LARGE_SLOTS-1:0] large_busy_reg;
    logic [LARGE_SLOTS-1:0] large_busy_next;

    usbfsa_pkg::rsp_t   out_data_next;

    logic               advance;
    logic               fire;

    logic               small_found;
    logic [SIDX_W-1:0]  small_idx;
    logic               large_found;
    logic [LIDX_W-1:0]  large_idx;

    logic [11:0]        small_diff;
    logic [11:0]        large_diff;
    logic               in_small_pool;
    logic               in_large_pool;
    logic [SIDX_W-1:0]  free_small_idx;
    logic [LIDX_W-1:0]  free_large_idx;

    // The result register can take a new value when it is empty or drained.
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    usbfsa_lowest_free #(
        .N (SMALL_SLOTS)
    ) u_small_enc (
        .busy  (small_busy_reg),
        .found (small_found),
        .idx   (small_idx)
    );

    usbfsa_lowest_free #(
        .N (LARGE_SLOTS)
    ) u_large_enc (
        .busy  (large_busy_reg),
        .found (large_found),
        .idx   (large_idx)
    );

    // Free-address decode. Addresses inside a slot map to that slot.
    assign small_diff     = in_data_reg.fifo_address - 12'(usbfsa_pkg::EP0_UNITS);
    assign large_diff     = in_data_reg.fifo_address - 12'(LARGE_BASE);
    assign in_small_pool  = (in_data_reg.fifo_address >= 12'(usbfsa_pkg::EP0_UNITS))
                            && (in_data_reg.fifo_address < 12'(LARGE_BASE));
    assign in_large_pool  = (in_data_reg.fifo_address >= 12'(LARGE_BASE))
                            && (large_diff < 12'(LARGE_SPAN));
    assign free_small_idx = small_diff[3 +: SIDX_W];
    assign free_large_idx = large_diff[5 +: LIDX_W];

    always_comb
    begin
        small_busy_next            = small_busy_reg;
        large_busy_next            = large_busy_reg;
        out_data_next.slot_address = '0;
        out_data_next.status       = usbfsa_pkg::STATUS_OK;

        if (in_data_reg.mode == usbfsa_pkg::MODE_ALLOC)
        begin
            priority if (in_data_reg.packet_size > usbfsa_pkg::LARGE_MAX_BYTES)
            begin
                out_data_next.status = usbfsa_pkg::STATUS_NO_SPACE;
            end
            else if ((in_data_reg.packet_size <= usbfsa_pkg::SMALL_MAX_BYTES)
                     && small_found)
            begin
                small_busy_next[small_idx] = 1'b1;
                out_data_next.slot_address = 12'(usbfsa_pkg::EP0_UNITS)
                                             + (12'(small_idx) << 3);
            end
            else if (large_found)
            begin
                large_busy_next[large_idx] = 1'b1;
                out_data_next.slot_address = 12'(LARGE_BASE) + (12'(large_idx) << 5);
            end
            else
            begin
                out_data_next.status = usbfsa_pkg::STATUS_NO_SPACE;
            end
        end
        else
        begin
            priority if (in_small_pool)
            begin
                small_busy_next[free_small_idx] = 1'b0;
            end
            else if (in_large_pool)
            begin
                large_busy_next[free_large_idx] = 1'b0;
            end
            else
            begin
                out_data_next.status = usbfsa_pkg::STATUS_BAD_ADDR;
            end
        end
    end

    // Control state and bitmaps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            small_busy_reg <= '0;
            large_busy_reg <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                small_busy_reg <= small_busy_next;
                large_busy_reg <= large_busy_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A failed request never reports an address.
    `USBFSA_ASSERT_SAME(a_fail_zero_addr,
        out_valid_reg && (out_data_reg.status != usbfsa_pkg::STATUS_OK),
        out_data_reg.slot_address == 12'd0)

    // While the result waits, no request is processed and the bitmaps hold.
    `USBFSA_ASSERT_NEXT(a_stall_holds_busy,
        out_valid_reg && !rsp.ready,
        $stable(small_busy_reg) && $stable(large_busy_reg))

    // A free request only ever clears busy bits.
    `USBFSA_ASSERT_NEXT(a_free_never_sets,
        fire && (in_data_reg.mode == usbfsa_pkg::MODE_FREE),
        ((small_busy_reg & ~$past(small_busy_reg)) == '0)
        && ((large_busy_reg & ~$past(large_busy_reg)) == '0))

endmodule
